// ===== hw/rtl/spzd_pkg.sv =====
// Shared types and constants for the swing pivot zone detector.
// No dependencies; every other file in hw/rtl imports this package.
package spzd_pkg;

    localparam int unsigned IdxW   = 32;
    localparam int unsigned PriceW = 32;
    localparam int unsigned SegW   = 8;

    // swing point kind
    localparam logic OP_TOP    = 1'b0;
    localparam logic OP_BOTTOM = 1'b1;

    localparam logic [SegW-1:0] SEG_MAX      = '1;
    localparam logic [SegW-1:0] SEG_DONE_MIN = SegW'(2);

    typedef logic        [IdxW-1:0]   t_idx;
    typedef logic signed [PriceW-1:0] t_price;
    typedef logic        [SegW-1:0]   t_seg;

    typedef struct packed {
        logic   op;
        t_idx   bar_index;
        t_price price;
    } t_in_item;

    typedef struct packed {
        logic   completed;
        logic   in_zone;
        t_idx   zone_start;
        t_idx   zone_end;
        t_price zone_high;
        t_price zone_low;
        t_price prior_high;
        t_price prior_low;
        t_seg   segment_count;
    } t_out_item;

    typedef struct packed {
        logic   zone_open;
        t_seg   segments;
        t_idx   top_recent_idx;
        t_idx   top_older_idx;
        t_idx   bot_recent_idx;
        t_idx   bot_older_idx;
        t_price top_recent_val;
        t_price top_older_val;
        t_price bot_recent_val;
        t_price bot_older_val;
        t_price upper_bound;
        t_price lower_bound;
        t_price saved_upper;
        t_price saved_lower;
        t_idx   start_idx;
        t_idx   end_idx;
    } t_state;

endpackage

// ===== hw/rtl/spzd_in_if.sv =====
// Valid/ready channel carrying one swing point per beat.
// Depends on spzd_pkg.
interface spzd_in_if;
    import spzd_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/spzd_out_if.sv =====
// Valid/ready channel carrying one zone result per beat.
// Depends on spzd_pkg.
interface spzd_out_if;
    import spzd_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/spzd_step.sv =====
// Next-state and result logic for one swing point.
// Pure combinational; depends on spzd_pkg.
module spzd_step (
    input  spzd_pkg::t_state    i_state,
    input  spzd_pkg::t_in_item  i_item,
    output spzd_pkg::t_state    o_state,
    output spzd_pkg::t_out_item o_result
);
    import spzd_pkg::*;

    t_state s;
    logic   done;
    t_price ub_min;
    t_price lb_max;

    always_comb begin
        s      = i_state;
        done   = 1'b0;
        ub_min = '0;
        lb_max = '0;

        if (i_state.zone_open) begin
            s.segments    = (i_state.segments != SEG_MAX) ? i_state.segments + t_seg'(1)
                                                          : i_state.segments;
            s.saved_upper = i_state.upper_bound;
            s.saved_lower = i_state.lower_bound;
        end else begin
            s.segments = '0;
        end

        if (i_item.op == OP_TOP) begin
            s.top_older_idx  = i_state.top_recent_idx;
            s.top_older_val  = i_state.top_recent_val;
            s.top_recent_idx = i_item.bar_index;
            s.top_recent_val = i_item.price;
            if (!i_state.zone_open) begin
                ub_min = (i_item.price < i_state.top_recent_val) ? i_item.price
                                                                 : i_state.top_recent_val;
                s.upper_bound = ub_min;
                if (ub_min > i_state.lower_bound) begin
                    s.start_idx = (i_state.bot_recent_val < i_state.bot_older_val)
                                  ? i_state.bot_older_idx : i_state.top_recent_idx;
                    s.zone_open = 1'b1;
                end
            end else begin
                ub_min = (i_item.price < i_state.upper_bound) ? i_item.price
                                                              : i_state.upper_bound;
                s.upper_bound = ub_min;
                if (ub_min < i_state.lower_bound) begin
                    // zone collapsed: bounds snap back to the latest swings
                    s.upper_bound = i_item.price;
                    s.lower_bound = i_state.bot_recent_val;
                    s.end_idx     = i_state.top_recent_idx;
                    s.zone_open   = 1'b0;
                    done          = s.segments > SEG_DONE_MIN;
                end
            end
        end else begin
            s.bot_older_idx  = i_state.bot_recent_idx;
            s.bot_older_val  = i_state.bot_recent_val;
            s.bot_recent_idx = i_item.bar_index;
            s.bot_recent_val = i_item.price;
            if (!i_state.zone_open) begin
                lb_max = (i_item.price > i_state.bot_recent_val) ? i_item.price
                                                                 : i_state.bot_recent_val;
                s.lower_bound = lb_max;
                if (i_state.upper_bound > lb_max) begin
                    s.start_idx = (i_state.top_recent_val > i_state.top_older_val)
                                  ? i_state.top_older_idx : i_state.bot_recent_idx;
                    s.zone_open = 1'b1;
                end
            end else begin
                lb_max = (i_item.price > i_state.lower_bound) ? i_item.price
                                                              : i_state.lower_bound;
                s.lower_bound = lb_max;
                if (i_state.upper_bound < lb_max) begin
                    s.upper_bound = i_state.top_recent_val;
                    s.lower_bound = i_item.price;
                    s.end_idx     = i_state.bot_recent_idx;
                    s.zone_open   = 1'b0;
                    done          = s.segments > SEG_DONE_MIN;
                end
            end
        end
    end

    assign o_state = s;

    assign o_result.completed     = done;
    assign o_result.in_zone       = s.zone_open;
    assign o_result.zone_start    = s.start_idx;
    assign o_result.zone_end      = s.end_idx;
    assign o_result.zone_high     = s.upper_bound;
    assign o_result.zone_low      = s.lower_bound;
    assign o_result.prior_high    = s.saved_upper;
    assign o_result.prior_low     = s.saved_lower;
    assign o_result.segment_count = s.segments;

endmodule

// ===== hw/rtl/swing_pivot_zone_detector_core.sv =====
// Swing pivot zone detector, top level.
// Depends on spzd_pkg, spzd_in_if, spzd_out_if and spzd_step.
//
// Usage:
//   i_pt carries one swing point per beat (op, bar_index, price); o_res
//   returns exactly one zone result per point, in order.
//   A point is captured in an input register; the zone state and the result
//   register are then updated together once the result register is free, so
//   a result passes through two register stages. One point per cycle is
//   sustained while o_res accepts; the only loop is the zone state update.
//   When o_res stalls, the result register holds and the input register
//   still takes one more point; i_pt.ready drops only while both are full.
//   Reset (synchronous, active low) empties both registers and clears the
//   zone state: no zone open, all bounds, indexes and counters at zero.
//   There are no configuration registers.
module swing_pivot_zone_detector_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    spzd_in_if.sink        i_pt,
    spzd_out_if.source     o_res
);
    import spzd_pkg::*;

    logic      r_in_vld;
    t_in_item  r_in_item;
    logic      r_out_vld;
    t_out_item r_out_item;
    t_state    r_state;

    t_state    n_state;
    t_out_item n_out_item;

    logic out_free;
    logic advance;

    assign out_free   = !r_out_vld || o_res.ready;
    assign advance    = r_in_vld && out_free;
    assign i_pt.ready = !r_in_vld || advance;

    spzd_step u_step (
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (i_pt.ready) begin
                r_in_vld <= i_pt.valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pt.ready && i_pt.valid) begin
            r_in_item <= i_pt.data;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out_item;

endmodule

// ===== tb/sv/swing_pivot_zone_detector_core_test.sv =====
// Testbench for swing_pivot_zone_detector_core: drives swing points, tracks the zone
// state alongside the block and compares every result beat field by field.
// Depends on spzd_pkg, spzd_in_if, spzd_out_if and the core RTL.
module swing_pivot_zone_detector_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spzd_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    spzd_in_if  pt_ch ();
    spzd_out_if res_ch ();

    swing_pivot_zone_detector_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_ch),
        .o_res   (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // zone tracker state
    logic   zone_active;
    t_seg   seg_cnt;
    t_idx   top_new_idx, top_old_idx, bot_new_idx, bot_old_idx;
    t_price top_new_px, top_old_px, bot_new_px, bot_old_px;
    t_price zone_hi, zone_lo, prev_hi, prev_lo;
    t_idx   zone_first_bar, zone_last_bar;

    t_out_item   pending_zones[$];
    int unsigned mismatch_count = 0;
    bit          steady = 1'b0;
    int unsigned hold_request = 0;

    function automatic t_out_item advance_zone_tracker(input t_in_item pt);
        t_out_item r;
        logic      done;
        done = 1'b0;
        if (zone_active) begin
            if (seg_cnt != SEG_MAX) seg_cnt = seg_cnt + 1'b1;
            prev_hi = zone_hi;
            prev_lo = zone_lo;
        end else begin
            seg_cnt = '0;
        end

        if (pt.op == OP_TOP) begin
            top_old_idx = top_new_idx;
            top_old_px  = top_new_px;
            top_new_idx = pt.bar_index;
            top_new_px  = pt.price;
            if (!zone_active) begin
                zone_hi = (top_new_px < top_old_px) ? top_new_px : top_old_px;
                if (zone_hi > zone_lo) begin
                    zone_first_bar = (bot_new_px < bot_old_px) ? bot_old_idx : top_old_idx;
                    zone_active = 1'b1;
                end
            end else begin
                if (zone_hi > top_new_px) zone_hi = top_new_px;
                if (zone_hi < zone_lo) begin
                    zone_hi = top_new_px;
                    zone_lo = bot_new_px;
                    zone_last_bar = top_old_idx;
                    zone_active = 1'b0;
                    done = seg_cnt > SEG_DONE_MIN;
                end
            end
        end else begin
            bot_old_idx = bot_new_idx;
            bot_old_px  = bot_new_px;
            bot_new_idx = pt.bar_index;
            bot_new_px  = pt.price;
            if (!zone_active) begin
                zone_lo = (bot_new_px > bot_old_px) ? bot_new_px : bot_old_px;
                if (zone_hi > zone_lo) begin
                    zone_first_bar = (top_new_px > top_old_px) ? top_old_idx : bot_old_idx;
                    zone_active = 1'b1;
                end
            end else begin
                if (zone_lo < bot_new_px) zone_lo = bot_new_px;
                if (zone_hi < zone_lo) begin
                    zone_hi = top_new_px;
                    zone_lo = bot_new_px;
                    zone_last_bar = bot_old_idx;
                    zone_active = 1'b0;
                    done = seg_cnt > SEG_DONE_MIN;
                end
            end
        end

        r.completed     = done;
        r.in_zone       = zone_active;
        r.zone_start    = zone_first_bar;
        r.zone_end      = zone_last_bar;
        r.zone_high     = zone_hi;
        r.zone_low      = zone_lo;
        r.prior_high    = prev_hi;
        r.prior_low     = prev_lo;
        r.segment_count = seg_cnt;
        return r;
    endfunction

    task automatic compare_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    task automatic check_zone_result(input t_out_item got);
        t_out_item exp_r;
        if (pending_zones.size() == 0) begin
            $error("result beat with no swing point outstanding");
            mismatch_count++;
        end else begin
            exp_r = pending_zones.pop_front();
            compare_field("completed", longint'(exp_r.completed), longint'(got.completed));
            compare_field("in_zone", longint'(exp_r.in_zone), longint'(got.in_zone));
            compare_field("zone_start", longint'(exp_r.zone_start), longint'(got.zone_start));
            compare_field("zone_end", longint'(exp_r.zone_end), longint'(got.zone_end));
            compare_field("zone_high", longint'(exp_r.zone_high), longint'(got.zone_high));
            compare_field("zone_low", longint'(exp_r.zone_low), longint'(got.zone_low));
            compare_field("prior_high", longint'(exp_r.prior_high), longint'(got.prior_high));
            compare_field("prior_low", longint'(exp_r.prior_low), longint'(got.prior_low));
            compare_field("segment_count", longint'(exp_r.segment_count),
                          longint'(got.segment_count));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) check_zone_result(res_ch.data);
    end

    // result side: random stalls, always ready when steady, or a long hold-off when requested
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (steady) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= 33);
            end
        end
    end

    // valid stays high between back-to-back beats; it only drops during a gap
    task automatic send_point(input logic op, input t_idx bar, input t_price px);
        t_in_item    pt;
        int unsigned gap;
        pt.op = op;
        pt.bar_index = bar;
        pt.price = px;
        gap = 0;
        if (!steady) begin
            while (gap < 12 && $urandom_range(99) < 33) begin
                pt_ch.valid <= 1'b0;
                @(posedge i_clk);
                gap++;
            end
        end
        pt_ch.valid <= 1'b1;
        pt_ch.data  <= pt;
        do @(posedge i_clk); while (!pt_ch.ready);
        pending_zones.push_back(advance_zone_tracker(pt));
    endtask

    task automatic test_directed_cases();
        send_point(OP_TOP,    32'd10,  32'sd100);   // equal bounds, nothing opens
        send_point(OP_BOTTOM, 32'd20,  -32'sd50);
        send_point(OP_TOP,    32'd30,  32'sd120);   // opens on a top, falling bottoms
        send_point(OP_BOTTOM, 32'd40,  -32'sd40);
        send_point(OP_TOP,    32'd50,  32'sd90);
        send_point(OP_BOTTOM, 32'd60,  32'sd30);
        send_point(OP_TOP,    32'd70,  32'sd20);    // closes on a top, completed
        send_point(OP_BOTTOM, 32'd80,  32'sd10);
        send_point(OP_BOTTOM, 32'd90,  32'sd5);     // opens on a bottom, tops falling
        send_point(OP_BOTTOM, 32'd100, 32'sd25);    // same kind again, closes early
        send_point(OP_TOP,    32'd110, 32'sd200);
        send_point(OP_TOP,    32'd120, 32'sd300);   // opens on a top, bottoms rising
        send_point(OP_BOTTOM, 32'd130, 32'sd250);   // closes on a bottom
        send_point(OP_BOTTOM, 32'd140, 32'sd260);   // opens on a bottom, tops rising
        send_point(OP_TOP,    32'hFFFF_FFFF, 32'sh7FFF_FFFF);
        send_point(OP_BOTTOM, 32'h0000_0000, 32'sh8000_0000);
        send_point(OP_TOP,    32'h8000_0000, 32'sh8000_0000);
        send_point(OP_BOTTOM, 32'h7FFF_FFFF, 32'sh7FFF_FFFF);
    endtask

    // extreme swings keep the zone open well past the counter limit
    task automatic test_segment_saturation();
        t_idx bar;
        bar = 32'h0001_0000;
        send_point(OP_TOP,    bar,         32'sh7FFF_FFFF);
        send_point(OP_TOP,    bar + 32'd1, 32'sh7FFF_FFFF);
        send_point(OP_BOTTOM, bar + 32'd2, 32'sh8000_0000);
        send_point(OP_BOTTOM, bar + 32'd3, 32'sh8000_0000);
        bar = bar + 32'd4;
        for (int i = 0; i < 270; i++) begin
            if (i % 2 == 0) send_point(OP_TOP, bar, 32'sh7FFF_FFFF);
            else send_point(OP_BOTTOM, bar, 32'sh8000_0000);
            bar = bar + t_idx'($urandom_range(1, 9));
        end
        send_point(OP_TOP,    bar,         32'sh8000_0000);
        send_point(OP_BOTTOM, bar + 32'd1, 32'sh7FFF_FFFF);
    endtask

    // mostly alternating tops and bottoms around a drifting midline
    task automatic test_random_swings(input int unsigned n_points);
        t_price      mid;
        t_price      px;
        t_idx        bar;
        int unsigned span;
        int unsigned run_len;
        int unsigned sent;
        bit          top_next;
        sent = 0;
        mid = t_price'($urandom_range(0, 2000)) - 32'sd1000;
        bar = ($urandom_range(3) == 0) ? t_idx'($urandom) : t_idx'($urandom_range(0, 5000));
        while (sent < n_points) begin
            span = ($urandom_range(9) == 0) ? $urandom_range(1, 32'h3FFF_FFFF)
                                            : $urandom_range(1, 500);
            if ($urandom_range(7) == 0) mid = t_price'($urandom);
            run_len = $urandom_range(8, 40);
            top_next = ($urandom_range(1) != 0);
            for (int i = 0; i < run_len && sent < n_points; i++) begin
                if (top_next) px = mid + t_price'($urandom_range(0, span));
                else px = mid - t_price'($urandom_range(0, span));
                send_point(top_next ? OP_TOP : OP_BOTTOM, bar, px);
                mid = mid + t_price'($urandom_range(0, span)) - t_price'(span / 2);
                bar = bar + t_idx'($urandom_range(1, 25));
                // now and then the same kind twice
                if ($urandom_range(15) != 0) top_next = !top_next;
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        steady = 1'b1;
        hold_request = 150;
        test_random_swings(30);
        steady = 1'b0;
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        test_random_swings(120);
        steady = 1'b0;
    endtask

    task automatic test_random_noise(input int unsigned n_points);
        logic op;
        for (int i = 0; i < n_points; i++) begin
            op = ($urandom_range(4) == 0) ? OP_BOTTOM : logic'($urandom_range(1));
            send_point(op, t_idx'($urandom), t_price'($urandom));
        end
    endtask

    initial begin
        zone_active = 1'b0;
        seg_cnt = '0;
        top_new_idx = '0;
        top_old_idx = '0;
        bot_new_idx = '0;
        bot_old_idx = '0;
        top_new_px = '0;
        top_old_px = '0;
        bot_new_px = '0;
        bot_old_px = '0;
        zone_hi = '0;
        zone_lo = '0;
        prev_hi = '0;
        prev_lo = '0;
        zone_first_bar = '0;
        zone_last_bar = '0;

        i_rst_n <= 1'b0;
        pt_ch.valid <= 1'b0;
        pt_ch.data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_segment_saturation();
        test_random_swings(256);
        test_backpressure();
        test_steady_stream();
        test_random_noise(150);

        pt_ch.valid <= 1'b0;
        while (pending_zones.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** swing_pivot_zone_detector_core: PASSED **");
        end else begin
            $display("** swing_pivot_zone_detector_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("** swing_pivot_zone_detector_core: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/spzd_pkg.sv
hw/rtl/spzd_in_if.sv
hw/rtl/spzd_out_if.sv
hw/rtl/spzd_step.sv
hw/rtl/swing_pivot_zone_detector_core.sv
tb/sv/swing_pivot_zone_detector_core_test.sv
